@@ hw/rtl/clt_pkg.sv @@
// Shared types, constants and lookup functions for the cheat line type decoder.
// Depends on nothing; every other file of the block imports it.
package clt_pkg;

   // Record type codes with a meaning of their own
   localparam logic signed [7:0] SZ_NONE   = -8'sd1;
   localparam logic signed [7:0] SZ_MASTER = 8'sd112;

   // Record type codes of the nibble-typed format
   localparam logic signed [7:0] SZ_WR8    = 8'sd0;
   localparam logic signed [7:0] SZ_WR16B  = 8'sd1;
   localparam logic signed [7:0] SZ_KEY    = 8'sd7;
   localparam logic signed [7:0] SZ_IF8    = 8'sd8;
   localparam logic signed [7:0] SZ_SLIDE  = 8'sd9;
   localparam logic signed [7:0] SZ_IFEQ   = 8'sd10;
   localparam logic signed [7:0] SZ_AND    = 8'sd11;
   localparam logic signed [7:0] SZ_ADD    = 8'sd32;
   localparam logic signed [7:0] SZ_WR16   = 8'sd33;
   localparam logic signed [7:0] SZ_IFLT   = 8'sd34;
   localparam logic signed [7:0] SZ_IFNE   = 8'sd35;
   localparam logic signed [7:0] SZ_MULTI  = 8'sd36;
   localparam logic signed [7:0] SZ_IFGT   = 8'sd50;

   // Top nibble of a nibble-typed address word
   localparam logic [3:0] NIB_RAW    = 4'h0;
   localparam logic [3:0] NIB_MASTER = 4'h1;
   localparam logic [3:0] NIB_WR16   = 4'h2;
   localparam logic [3:0] NIB_WR8    = 4'h3;
   localparam logic [3:0] NIB_SLIDE  = 4'h4;
   localparam logic [3:0] NIB_MULTI  = 4'h5;
   localparam logic [3:0] NIB_AND    = 4'h6;
   localparam logic [3:0] NIB_IF8    = 4'h7;
   localparam logic [3:0] NIB_WR16B  = 4'h8;
   localparam logic [3:0] NIB_UNUSED = 4'h9;
   localparam logic [3:0] NIB_IFEQ   = 4'hA;
   localparam logic [3:0] NIB_IFNE   = 4'hB;
   localparam logic [3:0] NIB_IFLT   = 4'hC;
   localparam logic [3:0] NIB_KEY    = 4'hD;
   localparam logic [3:0] NIB_ADD    = 4'hE;
   localparam logic [3:0] NIB_IFGT   = 4'hF;

   // Address masks
   localparam logic [31:0] M_ADDR_EVEN = 32'h0FFF_FFFE;
   localparam logic [31:0] M_ADDR_LOW  = 32'h0FFF_FFFF;
   localparam logic [31:0] M_MASTER_LO = 32'h01FF_FFFF;
   localparam logic [31:0] M_MASTER_HI = 32'h0800_0000;
   localparam logic [31:0] M_SIGN_FILL = 32'hFFFF_0000;
   localparam logic [31:0] M_KEY_ADDR  = 32'h0000_00F0;
   localparam logic [31:0] M_LOW24     = 32'h00FF_FFFF;

   // Decrypted master code: top seven address bits of 0xC4 / 0xC5
   localparam logic [6:0] MASTER_TOP7 = 7'h62;
   // Lowest key-test nibble that makes the entry invalid
   localparam logic [3:0] KEY_BAD_MIN = 4'd3;
   // floor(x / 3) for 16-bit x is (x * DIV3_RECIP) >> DIV3_SHIFT
   localparam logic [16:0] DIV3_RECIP = 17'h0AAAB;
   localparam int          DIV3_SHIFT = 17;

   // Item passed from the front end to the back end
   typedef struct packed {
      logic        cmd;
      logic        data_line;
      logic        bad_key;
      logic        entry_error;
      logic [31:0] addr;
      logic [31:0] value;
   } clt_item_type;

   // Regroup split address bits: bits 23..20 move up to 27..24, 17..0 stay
   function automatic logic [31:0] regroup(input logic [31:0] w);
      return {4'b0, w[23:20], 6'b0, w[17:0]};
   endfunction

   // Type code table of the decrypted format
   function automatic logic signed [7:0] fmt1_type_code(input logic [7:0] t);
      logic signed [7:0] r;
      unique case (t)
         8'h00: r = 8'sd23;  8'h01: r = 8'sd24;  8'h02: r = 8'sd2;
         8'h04: r = 8'sd19;  8'h05: r = 8'sd8;   8'h06: r = 8'sd20;
         8'h07: r = 8'sd61;  8'h08: r = 8'sd21;  8'h09: r = 8'sd10;
         8'h0A: r = 8'sd22;  8'h0C: r = 8'sd63;  8'h0D: r = 8'sd64;
         8'h0E: r = 8'sd65;  8'h10: r = 8'sd66;  8'h11: r = 8'sd67;
         8'h12: r = 8'sd68;  8'h14: r = 8'sd43;  8'h15: r = 8'sd44;
         8'h16: r = 8'sd45;  8'h18: r = 8'sd46;  8'h19: r = 8'sd47;
         8'h1A: r = 8'sd48;  8'h1C: r = 8'sd49;  8'h1D: r = 8'sd50;
         8'h1E: r = 8'sd51;  8'h20: r = 8'sd37;  8'h21: r = 8'sd38;
         8'h22: r = 8'sd39;  8'h24: r = 8'sd25;  8'h25: r = 8'sd26;
         8'h26: r = 8'sd27;  8'h27: r = 8'sd62;  8'h28: r = 8'sd28;
         8'h29: r = 8'sd29;  8'h2A: r = 8'sd30;  8'h2C: r = 8'sd69;
         8'h2D: r = 8'sd70;  8'h2E: r = 8'sd71;  8'h30: r = 8'sd72;
         8'h31: r = 8'sd73;  8'h32: r = 8'sd74;  8'h34: r = 8'sd52;
         8'h35: r = 8'sd53;  8'h36: r = 8'sd54;  8'h38: r = 8'sd55;
         8'h39: r = 8'sd56;  8'h3A: r = 8'sd57;  8'h3C: r = 8'sd58;
         8'h3D: r = 8'sd59;  8'h3E: r = 8'sd60;  8'h40: r = 8'sd40;
         8'h41: r = 8'sd41;  8'h42: r = 8'sd42;  8'h44: r = 8'sd78;
         8'h45: r = 8'sd79;  8'h46: r = 8'sd80;  8'h47: r = 8'sd99;
         8'h48: r = 8'sd81;  8'h49: r = 8'sd82;  8'h4A: r = 8'sd83;
         8'h4C: r = 8'sd84;  8'h4D: r = 8'sd85;  8'h4E: r = 8'sd86;
         8'h50: r = 8'sd87;  8'h51: r = 8'sd88;  8'h52: r = 8'sd89;
         8'h54: r = 8'sd90;  8'h55: r = 8'sd91;  8'h56: r = 8'sd92;
         8'h58: r = 8'sd93;  8'h59: r = 8'sd94;  8'h5A: r = 8'sd95;
         8'h5C: r = 8'sd96;  8'h5D: r = 8'sd97;  8'h5E: r = 8'sd98;
         8'h63: r = 8'sd75;  8'hE3: r = 8'sd76;
         default: r = SZ_NONE;
      endcase
      return r;
   endfunction

   // Extended type of a decrypted line whose address word is zero.
   // use_low24: value keeps its low 24 bits; otherwise value is regrouped.
   function automatic logic signed [7:0] fmt1_ext_code(input logic [6:0] et,
                                                       output logic use_low24);
      logic signed [7:0] r;
      use_low24 = 1'b0;
      unique case (et)
         7'h04: begin r = 8'sd31;  use_low24 = 1'b1; end
         7'h08: r = 8'sd12;
         7'h09: r = 8'sd13;
         7'h0A: r = 8'sd14;
         7'h0C: begin r = 8'sd15;  use_low24 = 1'b1; end
         7'h0D: begin r = 8'sd100; use_low24 = 1'b1; end
         7'h0E: begin r = 8'sd101; use_low24 = 1'b1; end
         7'h0F: begin r = 8'sd102; use_low24 = 1'b1; end
         7'h20: r = 8'sd77;
         7'h40: r = 8'sd16;
         7'h41: r = 8'sd17;
         7'h42: r = 8'sd18;
         default: r = SZ_NONE;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/clt_front.sv @@
// Front end: accepts lines, tracks per-entry state and classifies each item.
// Depends on clt_pkg; pushes classified items into clt_queue.
module clt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic                  req_first_line,
   input  logic                  req_last_line,
   input  logic [31:0]           req_code_address,
   input  logic [31:0]           req_code_value,
   input  logic                  q_full,
   output logic                  q_push,
   output clt_pkg::clt_item_type q_item
);
   import clt_pkg::*;

   logic        prev_takes_ff, prev_takes_in;
   logic [14:0] pending_ff, pending_in;
   logic        aborted_ff, aborted_in;

   logic        prev_cur;
   logic [14:0] pending_cur;
   logic        aborted_cur;
   logic [3:0]  nib;
   logic [15:0] val16;
   logic [15:0] val_m1;
   logic [32:0] div_prod;
   logic [14:0] multi_count;
   logic        take_data;
   logic        bad_key;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // A first line starts from cleared state
   assign prev_cur    = req_first_line ? 1'b0 : prev_takes_ff;
   assign pending_cur = req_first_line ? 15'd0 : pending_ff;
   assign aborted_cur = req_first_line ? 1'b0 : aborted_ff;

   assign nib   = req_code_address[31:28];
   assign val16 = req_code_value[15:0];

   // Multi-write data line count: ((value - 1) mod 2^16) / 3 + 1
   assign val_m1      = val16 - 16'd1;
   assign div_prod    = 33'(val_m1) * 33'(DIV3_RECIP);
   assign multi_count = div_prod[DIV3_SHIFT +: 15] + 15'd1;

   assign take_data = !req_cmd && (prev_cur || (pending_cur != 15'd0));
   assign bad_key   = !req_cmd && !take_data && (nib == NIB_KEY)
                      && (req_code_address[7:4] >= KEY_BAD_MIN);

   // Next state of the entry tracking
   always_comb begin
      prev_takes_in = prev_cur;
      pending_in    = pending_cur;
      aborted_in    = aborted_cur | bad_key;
      if (!req_cmd) begin
         if (take_data) begin
            prev_takes_in = 1'b0;
            if (pending_cur != 15'd0) pending_in = pending_cur - 15'd1;
         end else begin
            prev_takes_in = (nib == NIB_SLIDE) || (nib == NIB_MULTI);
            if (nib == NIB_MULTI) pending_in = multi_count;
         end
      end
   end

   // Classified item
   always_comb begin
      q_item.cmd         = req_cmd;
      q_item.data_line   = take_data;
      q_item.bad_key     = bad_key;
      q_item.entry_error = aborted_in || (req_last_line && (pending_in != 15'd0));
      q_item.addr        = req_code_address;
      q_item.value       = req_cmd ? req_code_value : {16'b0, val16};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_takes_ff <= 1'b0;
         pending_ff    <= 15'd0;
         aborted_ff    <= 1'b0;
      end else if (q_push) begin
         prev_takes_ff <= prev_takes_in;
         pending_ff    <= pending_in;
         aborted_ff    <= aborted_in;
      end
   end

endmodule

@@ hw/rtl/clt_queue.sv @@
// Short FIFO of classified items between the front end and the back end.
// Depends on clt_pkg for the item type.
module clt_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  clt_pkg::clt_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output clt_pkg::clt_item_type head_item
);
   import clt_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   clt_item_type     entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      if (do_push && !do_pop)      count_in = count_ff + CW'(1);
      else if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_item;
   end

endmodule

@@ hw/rtl/clt_back.sv @@
// Back end: decodes type code, address and value of each item into the
// registered result stage. Depends on clt_pkg.
module clt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  clt_pkg::clt_item_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_format_flag,
   output logic signed [7:0]     rsp_size_code,
   output logic [31:0]           rsp_target_address,
   output logic [31:0]           rsp_target_value,
   output logic                  rsp_data_line,
   output logic                  rsp_entry_error
);
   import clt_pkg::*;

   logic              valid_ff;
   logic              flag_ff, dline_ff, err_ff;
   logic signed [7:0] size_ff, size_in;
   logic [31:0]       addr_ff, addr_in;
   logic [31:0]       value_ff, value_in;
   logic              load;

   logic [31:0]       a, v;
   logic [3:0]        nib;
   logic [7:0]        t1;
   logic              use_low24;
   logic signed [7:0] ext_code;

   assign a   = q_head.addr;
   assign v   = q_head.value;
   assign nib = a[31:28];
   assign t1  = {a[24], a[31:25]};

   assign load  = !valid_ff || !rsp_stall;
   assign q_pop = load && !q_empty;

   // Record decode
   always_comb begin
      ext_code = fmt1_ext_code(v[31:25], use_low24);
      size_in  = SZ_NONE;
      addr_in  = a;
      value_in = v;
      if (!q_head.cmd) begin
         if (!q_head.data_line) begin
            unique case (nib)
               NIB_RAW:    addr_in = a & M_ADDR_LOW;
               NIB_MASTER: begin
                  size_in = SZ_MASTER;
                  addr_in = (a & M_MASTER_LO) | M_MASTER_HI;
               end
               NIB_WR16:   begin size_in = SZ_WR16;  addr_in = a & M_ADDR_EVEN; end
               NIB_WR8:    begin size_in = SZ_WR8;   addr_in = a & M_ADDR_LOW;  end
               NIB_SLIDE:  begin size_in = SZ_SLIDE; addr_in = a & M_ADDR_EVEN; end
               NIB_MULTI:  begin size_in = SZ_MULTI; addr_in = a & M_ADDR_EVEN; end
               NIB_AND:    begin size_in = SZ_AND;   addr_in = a & M_ADDR_EVEN; end
               NIB_IF8:    begin size_in = SZ_IF8;   addr_in = a & M_ADDR_EVEN; end
               NIB_WR16B:  begin size_in = SZ_WR16B; addr_in = a & M_ADDR_EVEN; end
               NIB_UNUSED: addr_in = a;
               NIB_IFEQ:   begin size_in = SZ_IFEQ;  addr_in = a & M_ADDR_EVEN; end
               NIB_IFNE:   begin size_in = SZ_IFNE;  addr_in = a & M_ADDR_EVEN; end
               NIB_IFLT:   begin size_in = SZ_IFLT;  addr_in = a & M_ADDR_EVEN; end
               NIB_KEY: begin
                  if (!q_head.bad_key) begin
                     size_in = SZ_KEY;
                     addr_in = a & M_KEY_ADDR;
                  end
               end
               NIB_ADD: begin
                  size_in = SZ_ADD;
                  addr_in = a & M_ADDR_LOW;
                  if (v[15]) value_in = v | M_SIGN_FILL;
               end
               NIB_IFGT:   begin size_in = SZ_IFGT;  addr_in = a & M_ADDR_EVEN; end
               default:    addr_in = a;
            endcase
         end
      end else if (a[31:25] == MASTER_TOP7) begin
         size_in = SZ_MASTER;
         addr_in = (a & M_MASTER_LO) | M_MASTER_HI;
      end else if (a == 32'd0) begin
         // Extended line: type and embedded address sit in the value word
         size_in = ext_code;
         if (ext_code != SZ_NONE)
            value_in = use_low24 ? (v & M_LOW24) : regroup(v);
      end else begin
         addr_in = regroup(a);
         size_in = fmt1_type_code(t1);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (load) valid_ff <= !q_empty;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         flag_ff  <= q_head.cmd;
         size_ff  <= size_in;
         addr_ff  <= addr_in;
         value_ff <= value_in;
         dline_ff <= q_head.data_line;
         err_ff   <= q_head.entry_error;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_format_flag    = flag_ff;
   assign rsp_size_code      = size_ff;
   assign rsp_target_address = addr_ff;
   assign rsp_target_value   = value_ff;
   assign rsp_data_line      = dline_ff;
   assign rsp_entry_error    = err_ff;

endmodule

@@ hw/rtl/cheat_line_type_decoder.sv @@
// Cheat line type decoder: one decoded cheat line in, one typed record out.
// Request channel (req_*): valid/stall; an item is taken when req_valid is
//   high and req_stall is low. req_stall rises only when the internal queue
//   is full.
// Result channel (rsp_*): valid/stall; the record is held while rsp_stall
//   is high.
// Path: an accepted line is written into the queue; the back end then
//   decodes the queue head and registers the record in the result register.
// Throughput: one line per cycle while req_stall is low. The front end
//   updates the per-entry state (slide flag, multi-write count, abort flag)
//   in the accepting cycle; the back end decodes and registers one queued
//   item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds, the queue fills
//   (QUEUE_DEPTH items) and only then is req_stall raised.
// Reset (synchronous, active high) empties the queue and the result stage
//   and clears the per-entry state; there is no startup sequence.
// Depends on clt_pkg, clt_front, clt_queue and clt_back.
module cheat_line_type_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic              req_first_line,
   input  logic              req_last_line,
   input  logic [31:0]       req_code_address,
   input  logic [31:0]       req_code_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_format_flag,
   output logic signed [7:0] rsp_size_code,
   output logic [31:0]       rsp_target_address,
   output logic [31:0]       rsp_target_value,
   output logic              rsp_data_line,
   output logic              rsp_entry_error
);
   import clt_pkg::*;

   clt_item_type push_item, head_item;
   logic         push, full, pop, empty;

   // Front end: accept and classify
   clt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_first_line   (req_first_line),
      .req_last_line    (req_last_line),
      .req_code_address (req_code_address),
      .req_code_value   (req_code_value),
      .q_full           (full),
      .q_push           (push),
      .q_item           (push_item)
   );

   // Decoupling queue
   clt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head_item (head_item)
   );

   // Back end: decode and deliver
   clt_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (empty),
      .q_head             (head_item),
      .q_pop              (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_format_flag    (rsp_format_flag),
      .rsp_size_code      (rsp_size_code),
      .rsp_target_address (rsp_target_address),
      .rsp_target_value   (rsp_target_value),
      .rsp_data_line      (rsp_data_line),
      .rsp_entry_error    (rsp_entry_error)
   );

endmodule

@@ hw/rtl/clt_checker.sv @@
// Port-level checks for the cheat line type decoder, bound to the top level.
// Depends on clt_pkg and the top level's port names.
module clt_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_format_flag,
   input logic signed [7:0] rsp_size_code,
   input logic [31:0]       rsp_target_address,
   input logic [31:0]       rsp_target_value,
   input logic              rsp_data_line
);
   import clt_pkg::*;

   // No record comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("record valid right after reset");

   // A stalled record stays put
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_target_address)
         && $stable(rsp_target_value) && $stable(rsp_size_code))
      else $error("stalled record changed");

   // Data lines are untyped and only occur in the nibble-typed format
   a_data_untyped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_line |-> !rsp_format_flag && rsp_size_code == SZ_NONE)
      else $error("data line with a type code");

   // Master code address is rebuilt into the 0x08000000-0x09FFFFFF window
   a_master_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_code == SZ_MASTER |->
         rsp_target_address[31:25] == 7'h04)
      else $error("master code address not rebuilt");

   // Nibble-typed values never carry bits above 15 unless sign-filled
   a_fmt0_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_format_flag && rsp_size_code != SZ_ADD |->
         rsp_target_value[31:16] == 16'h0000)
      else $error("nibble-typed value wider than 16 bits");

endmodule

bind cheat_line_type_decoder clt_checker u_clt_checker (.*);
